>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the rtl, all sampled on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSRMV_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSRMV_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/csrmv_pkg.sv
// ----------------------------------------------------------------------------
// csrmv_pkg
// shared constants, codes and types of the sparse matvec accumulate core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csrmv_pkg;

   // vector store depth and address width
   localparam int VECTOR_DEPTH = 1024;
   localparam int VEC_AW       = $clog2(VECTOR_DEPTH);

   // field widths
   localparam int IDX_W  = 10;
   localparam int COL_W  = 24;
   localparam int DATA_W = 32;

   // csr port
   localparam int CSR_AW = 3;
   localparam logic CSR_IDX_START_COLUMN = 1'b0;

   typedef logic [1:0] req_kind_type;
   typedef logic [1:0] status_type;

   localparam req_kind_type REQ_WRITE_X = 2'd0;
   localparam req_kind_type REQ_WRITE_Y = 2'd1;
   localparam req_kind_type REQ_READ_Y  = 2'd2;
   localparam req_kind_type REQ_ACCUM   = 2'd3;

   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_RANGE = 2'd1;
   localparam status_type ST_SAT   = 2'd2;

   // multiply-accumulate result handed to the sequencer
   typedef struct packed {
      logic                     sat;
      logic signed [DATA_W-1:0] sum;
      logic signed [DATA_W-1:0] y_old;
   } mac_out_type;

endpackage

`default_nettype wire

>>> rtl/csrmv_ram.sv
// ----------------------------------------------------------------------------
// csrmv_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csrmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/csrmv_csr.sv
// ----------------------------------------------------------------------------
// csrmv_csr
// apb register block holding start_column
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csrmv_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [csrmv_pkg::CSR_AW-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready,
   output logic      [csrmv_pkg::COL_W-1:0] start_column
);
   import csrmv_pkg::*;

   logic [COL_W-1:0] start_column_ff;
   logic [COL_W-1:0] start_column_in;
   logic             reg_idx;
   logic             wr_beat;

   // byte lanes ignored, one word per register
   assign reg_idx = paddr[CSR_AW-1];
   assign pready  = 1'b1;
   assign wr_beat = psel && penable && pwrite && pready;

   always_comb begin
      start_column_in = start_column_ff;
      if (wr_beat && (reg_idx == CSR_IDX_START_COLUMN)) begin
         start_column_in = pwdata[COL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_column_ff <= '0;
      end else begin
         start_column_ff <= start_column_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == CSR_IDX_START_COLUMN) begin
         prdata = {{(32-COL_W){1'b0}}, start_column_ff};
      end
   end

   assign start_column = start_column_ff;

endmodule

`default_nettype wire

>>> rtl/csrmv_mac.sv
// ----------------------------------------------------------------------------
// csrmv_mac
// q16.16 multiply with registered product, then saturating add into y
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csrmv_mac (
   input  wire logic                                clock,
   input  wire logic                                load,
   input  wire logic signed [csrmv_pkg::DATA_W-1:0] value,
   input  wire logic signed [csrmv_pkg::DATA_W-1:0] x_data,
   input  wire logic signed [csrmv_pkg::DATA_W-1:0] y_data,
   output csrmv_pkg::mac_out_type                   result
);
   import csrmv_pkg::*;

   localparam int PROD_W = 2 * DATA_W;
   localparam int SUM_W  = PROD_W - 16 + 1;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [DATA_W-1:0] y_ff;
   logic signed [SUM_W-1:0]  sum_wide;
   logic                     over_pos;
   logic                     over_neg;

   assign prod_in = value * x_data;

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
         y_ff    <= y_data;
      end
   end

   // floor shift by 16 is just dropping the low bits
   assign sum_wide = $signed({{(SUM_W-DATA_W){y_ff[DATA_W-1]}}, y_ff})
                   + $signed({prod_ff[PROD_W-1], prod_ff[PROD_W-1:16]});

   assign over_pos = !sum_wide[SUM_W-1] && (|sum_wide[SUM_W-2:DATA_W-1]);
   assign over_neg = sum_wide[SUM_W-1] && !(&sum_wide[SUM_W-2:DATA_W-1]);

   always_comb begin
      result.y_old = y_ff;
      result.sat   = over_pos || over_neg;
      if (over_pos) begin
         result.sum = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (over_neg) begin
         result.sum = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         result.sum = sum_wide[DATA_W-1:0];
      end
   end

endmodule

`default_nettype wire

>>> rtl/csr_sparse_matvec_accumulate_core.sv
// ----------------------------------------------------------------------------
// csr_sparse_matvec_accumulate_core
// compressed-row sparse matrix times dense vector, one nonzero per command
// ----------------------------------------------------------------------------
//  channel   ports                                  handshake
//  ------    -----                                  ---------
//  request   req_type, req_local_index,             start && !busy
//            req_global_column, req_data_value
//  result    rsp_status, rsp_read_value             rsp_strobe, one cycle
//  csr       psel penable pwrite paddr pwdata       apb write, pready tied high
//            prdata pready
//
//  every command runs a ram read (x and y in parallel), a registered
//  multiply, then saturating add with y write-back; the beat leaves on the
//  cycle after write-back, while the next command may already be accepted
//  after reset every entry of the y store is swept to zero with busy high
//  busy stays high until write-back is done, so a read never meets a pending
//  write to the same entry
//  the result side cannot stall; csr writes are taken at any time
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module csr_sparse_matvec_accumulate_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // command
   input  wire logic                                start,
   output logic                                     busy,
   input  wire csrmv_pkg::req_kind_type             req_type,
   input  wire logic        [csrmv_pkg::IDX_W-1:0]  req_local_index,
   input  wire logic        [csrmv_pkg::COL_W-1:0]  req_global_column,
   input  wire logic signed [csrmv_pkg::DATA_W-1:0] req_data_value,
   // result
   output logic                                     rsp_strobe,
   output csrmv_pkg::status_type                    rsp_status,
   output logic signed      [csrmv_pkg::DATA_W-1:0] rsp_read_value,
   // csr
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic        [csrmv_pkg::CSR_AW-1:0] paddr,
   input  wire logic        [31:0]                  pwdata,
   output logic             [31:0]                  prdata,
   output logic                                     pready
);
   import csrmv_pkg::*;

   // sequencer states
   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_MUL   = 2'd2;
   localparam logic [1:0] S_WB    = 2'd3;

   logic [1:0]              state_ff;
   logic [1:0]              state_in;
   logic [VEC_AW-1:0]       clr_cnt_ff;
   logic [VEC_AW-1:0]       clr_cnt_in;

   // command held across the pipeline
   req_kind_type            type_ff;
   logic [IDX_W-1:0]        idx_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic                    idx_bad_ff;
   logic                    col_bad_ff;

   // result beat
   logic                    rsp_strobe_ff;
   logic                    rsp_strobe_in;
   status_type              rsp_status_ff;
   status_type              rsp_status_in;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic signed [DATA_W-1:0] rsp_value_in;

   logic                    accept;
   logic                    clearing;
   logic                    wb;
   logic [COL_W-1:0]        start_column;
   logic [COL_W:0]          col_diff;
   logic                    idx_bad;
   logic                    col_bad;
   logic [VEC_AW-1:0]       row_addr;
   logic [VEC_AW-1:0]       col_addr;
   logic [VEC_AW-1:0]       hold_addr;

   logic                    x_we;
   logic                    y_we;
   logic [VEC_AW-1:0]       y_waddr;
   logic [DATA_W-1:0]       y_wdata;
   logic [DATA_W-1:0]       x_rdata;
   logic [DATA_W-1:0]       y_rdata;
   mac_out_type             mac_out;

   // ---------------------------------------------------------------- csr
   csrmv_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .start_column (start_column)
   );

   // ---------------------------------------------------------------- accept
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign clearing = (state_ff == S_CLEAR);
   assign wb       = (state_ff == S_WB);

   // entry index and local column range checks
   assign idx_bad  = (32'(req_local_index) >= 32'(VECTOR_DEPTH));
   assign col_diff = {1'b0, req_global_column} - {1'b0, start_column};
   assign col_bad  = col_diff[COL_W] || (32'(col_diff[COL_W-1:0]) >= 32'(VECTOR_DEPTH));
   assign row_addr = VEC_AW'(req_local_index);
   assign col_addr = VEC_AW'(col_diff[COL_W-1:0]);

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == VEC_AW'(VECTOR_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            state_in = S_WB;
         end
         S_WB: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // command payload, captured on accept; result fields registered unconditionally
   always_ff @(posedge clock) begin
      if (accept) begin
         type_ff    <= req_type;
         idx_ff     <= req_local_index;
         value_ff   <= req_data_value;
         idx_bad_ff <= idx_bad;
         col_bad_ff <= col_bad;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // ---------------------------------------------------------------- stores
   assign hold_addr = VEC_AW'(idx_ff);

   assign x_we = wb && !idx_bad_ff && (type_ff == REQ_WRITE_X);

   always_comb begin
      y_we    = 1'b0;
      y_waddr = hold_addr;
      y_wdata = mac_out.sum;
      if (clearing) begin
         y_we    = 1'b1;
         y_waddr = clr_cnt_ff;
         y_wdata = '0;
      end else if (wb && !idx_bad_ff) begin
         if (type_ff == REQ_WRITE_Y) begin
            y_we    = 1'b1;
            y_wdata = value_ff;
         end else if ((type_ff == REQ_ACCUM) && !col_bad_ff) begin
            y_we = 1'b1;
         end
      end
   end

   csrmv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_x_ram (
      .clock   (clock),
      .wr_en   (x_we),
      .wr_addr (hold_addr),
      .wr_data (value_ff),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (x_rdata)
   );

   csrmv_ram #(
      .WIDTH (DATA_W),
      .DEPTH (VECTOR_DEPTH)
   ) u_y_ram (
      .clock   (clock),
      .wr_en   (y_we),
      .wr_addr (y_waddr),
      .wr_data (y_wdata),
      .rd_en   (accept),
      .rd_addr (row_addr),
      .rd_data (y_rdata)
   );

   // ---------------------------------------------------------------- mac
   csrmv_mac u_mac (
      .clock  (clock),
      .load   (state_ff == S_MUL),
      .value  (value_ff),
      .x_data ($signed(x_rdata)),
      .y_data ($signed(y_rdata)),
      .result (mac_out)
   );

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_strobe_in = wb;
      rsp_status_in = ST_OK;
      rsp_value_in  = '0;
      if (idx_bad_ff) begin
         rsp_status_in = ST_RANGE;
      end else begin
         case (type_ff)
            REQ_WRITE_X: begin
               rsp_value_in = '0;
            end
            REQ_WRITE_Y: begin
               rsp_value_in = value_ff;
            end
            REQ_READ_Y: begin
               rsp_value_in = mac_out.y_old;
            end
            REQ_ACCUM: begin
               if (col_bad_ff) begin
                  // y untouched, report what is there
                  rsp_status_in = ST_RANGE;
                  rsp_value_in  = mac_out.y_old;
               end else begin
                  rsp_status_in = mac_out.sat ? ST_SAT : ST_OK;
                  rsp_value_in  = mac_out.sum;
               end
            end
            default: begin
               rsp_value_in = '0;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_value_ff;

   // ---------------------------------------------------------------- checks
   `CSRMV_ASSERT_IMPL(a_beat_after_accept, start && !busy, ##3 rsp_strobe, "no beat 3 cycles after accept")
   `CSRMV_ASSERT_NEXT(a_single_beat, rsp_strobe, !rsp_strobe, "back-to-back result beats")
   `CSRMV_ASSERT_IMPL(a_no_beat_in_clear, state_ff == S_CLEAR, !rsp_strobe && busy, "beat or accept during clear")
   `CSRMV_ASSERT_IMPL(a_sat_at_bound, rsp_strobe && (rsp_status == ST_SAT), (rsp_read_value == 32'sh7fffffff) || (rsp_read_value == 32'sh80000000), "saturated value not at a bound")

endmodule

`default_nettype wire
